@@ src/cartesian_polar_converter_core_macros.svh @@
// ----------------------------------------------------------------------------
// cartesian_polar_converter_core_macros: assertion helpers
// same-cycle and next-cycle implications, sampled on the rising clock edge
// ----------------------------------------------------------------------------
`ifndef CARTESIAN_POLAR_CONVERTER_CORE_MACROS_SVH
`define CARTESIAN_POLAR_CONVERTER_CORE_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define CPC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error(msg);

// consequent must hold in the cycle after the antecedent
`define CPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

@@ src/cpc_pkg.sv @@
// ----------------------------------------------------------------------------
// cpc_pkg: shared types and constants of the coordinate converter
// fixed-point constants, arctangent table and stage-to-stage structs
// ----------------------------------------------------------------------------
package cpc_pkg;

	localparam int CPC_FIELD_W     = 32;
	localparam int CPC_DATA_BITS   = 6 * CPC_FIELD_W;
	localparam int CPC_DATA_WIDTH  = 32;
	localparam int CPC_STAGES      = 24;
	localparam int CPC_GUARD       = 8;
	localparam int CPC_HEAD        = 3;
	localparam int CPC_ZW          = 34;
	localparam int CPC_END_LAT     = 5;

	// inverse cordic gain, q0.32
	localparam logic [31:0]        CPC_KINV         = 32'd2608131496;
	// 2*pi in q3.28 per turn scaled for the azimuth output
	localparam logic [30:0]        CPC_TURN_TO_RAD  = 31'd1686629713;
	localparam logic signed [34:0] CPC_RAD_TO_TURN  = 35'sd10937044409;
	localparam logic [31:0]        CPC_HALF_TURN    = 32'h8000_0000;
	localparam logic signed [32:0] CPC_HALF_TURN_S  = 33'sd2147483648;
	localparam logic signed [32:0] CPC_QUARTER_TURN = 33'sd1073741824;

	typedef struct packed {
		logic                          mode;
		logic signed [CPC_FIELD_W-1:0] first_coord;
		logic signed [CPC_FIELD_W-1:0] second_coord;
		logic signed [CPC_FIELD_W-1:0] height;
		logic signed [CPC_FIELD_W-1:0] first_velocity;
		logic signed [CPC_FIELD_W-1:0] second_velocity;
		logic signed [CPC_FIELD_W-1:0] vertical_velocity;
		logic                          with_velocity;
	} cpc_item_t;

	// side band that rides along with each point through the chain
	typedef struct packed {
		logic                          mode;
		logic                          with_velocity;
		logic                          skip;
		logic                          half_turn;
		logic signed [CPC_FIELD_W-1:0] height;
		logic signed [CPC_FIELD_W-1:0] vz;
	} cpc_side_t;

	// usable data width is clipped to 16..32
	function automatic int cpc_dw(input int req);
		int dw;
		dw = req;
		if (dw > 32)
			dw = 32;
		if (dw < 16)
			dw = 16;
		return dw;
	endfunction

	// datapath width: guard bits below, headroom for gain and negation above
	function automatic int cpc_ww(input int dw);
		return dw + CPC_GUARD + CPC_HEAD;
	endfunction

	// atan(2^-i) in turns, 2^32 per turn
	function automatic logic [31:0] cpc_atan(input int idx);
		logic [31:0] v;
		case (idx)
			0:  v = 32'd536870912;
			1:  v = 32'd316933406;
			2:  v = 32'd167458907;
			3:  v = 32'd85004756;
			4:  v = 32'd42667331;
			5:  v = 32'd21354465;
			6:  v = 32'd10679838;
			7:  v = 32'd5340245;
			8:  v = 32'd2670163;
			9:  v = 32'd1335087;
			10: v = 32'd667544;
			11: v = 32'd333772;
			12: v = 32'd166886;
			13: v = 32'd83443;
			14: v = 32'd41722;
			15: v = 32'd20861;
			16: v = 32'd10430;
			17: v = 32'd5215;
			18: v = 32'd2608;
			19: v = 32'd1304;
			20: v = 32'd652;
			21: v = 32'd326;
			22: v = 32'd163;
			23: v = 32'd81;
			24: v = 32'd41;
			25: v = 32'd20;
			26: v = 32'd10;
			27: v = 32'd5;
			28: v = 32'd3;
			29: v = 32'd1;
			30: v = 32'd1;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

endpackage

@@ src/cartesian_polar_converter_core.sv @@
// ----------------------------------------------------------------------------
// cartesian_polar_converter_core: cartesian <-> cylindrical phase-space converter
// a request taken while the output is stalled waits in the skid
// throughput one request per cycle unless stalled, set by the unrolled chain of cordic cells
// arst_n clears every stage valid bit and the input skid; payload is not reset
// ----------------------------------------------------------------------------
`include "cartesian_polar_converter_core_macros.svh"

module cartesian_polar_converter_core #(
	parameter int DATA_WIDTH    = cpc_pkg::CPC_DATA_WIDTH,
	parameter int CORDIC_STAGES = cpc_pkg::CPC_STAGES
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// first_coord, second_coord, height, first_velocity, second_velocity,
	// vertical_velocity (32 bits each, lowest first)
	input  logic [cpc_pkg::CPC_DATA_BITS-1:0] s_tdata,
	// mode, with_velocity (lowest first)
	input  logic [1:0]                         s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// first_result, second_result, height_out, first_velocity_out,
	// second_velocity_out, vertical_velocity_out (32 bits each, lowest first)
	output logic [cpc_pkg::CPC_DATA_BITS-1:0] m_tdata,
	// saturated
	output logic [0:0]                         m_tuser
);
	import cpc_pkg::*;

	localparam int DW = cpc_dw(DATA_WIDTH);
	localparam int W  = cpc_ww(DW);
	localparam int N  = CORDIC_STAGES;
	localparam int FW = CPC_FIELD_W;

	// ------------------------------------------------------------------
	// input side: one-entry skid so ready is a flop and a request is
	// still taken while a finished result is held at the output
	// ------------------------------------------------------------------
	cpc_item_t in_item;
	cpc_item_t sk_item_q;
	logic      sk_valid_q;
	logic      en;
	logic      accept;
	logic      feed_valid;
	cpc_item_t feed_item;

	always_comb begin
		in_item.mode              = s_tuser[0];
		in_item.with_velocity     = s_tuser[1];
		in_item.first_coord       = s_tdata[0*FW +: FW];
		in_item.second_coord      = s_tdata[1*FW +: FW];
		in_item.height            = s_tdata[2*FW +: FW];
		in_item.first_velocity    = s_tdata[3*FW +: FW];
		in_item.second_velocity   = s_tdata[4*FW +: FW];
		in_item.vertical_velocity = s_tdata[5*FW +: FW];
	end

	// whole pipe moves when the output slot is free or being taken
	assign en         = !m_tvalid || m_tready;
	assign s_tready   = !sk_valid_q;
	assign accept     = s_tvalid && s_tready;
	// a parked request goes first; while parked no new request is taken
	assign feed_valid = sk_valid_q || accept;
	assign feed_item  = sk_valid_q ? sk_item_q : in_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sk_valid_q <= 1'b0;
		else if (en)
			sk_valid_q <= 1'b0;
		else if (accept)
			sk_valid_q <= 1'b1;
	end

	always_ff @(posedge clk) begin
		if (!en && accept)
			sk_item_q <= in_item;
	end

	// ------------------------------------------------------------------
	// operand setup: angle to turns, guard scaling, pre-rotation
	// ------------------------------------------------------------------
	logic                     cvalid [N+1];
	logic signed [W-1:0]      cx     [N+1];
	logic signed [W-1:0]      cy     [N+1];
	logic signed [W-1:0]      cvx    [N+1];
	logic signed [W-1:0]      cvy    [N+1];
	logic signed [CPC_ZW-1:0] cz     [N+1];
	cpc_side_t                cside  [N+1];

	cpc_prep #(
		.DW (DW),
		.W  (W)
	) u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (feed_valid),
		.in_item   (feed_item),
		.out_valid (cvalid[0]),
		.out_x     (cx[0]),
		.out_y     (cy[0]),
		.out_vx    (cvx[0]),
		.out_vy    (cvy[0]),
		.out_z     (cz[0]),
		.out_side  (cside[0])
	);

	// ------------------------------------------------------------------
	// cordic chain: cell g shifts by g and adds or subtracts atan(2^-g) in turns;
	// the velocity pair follows the same rotation decisions
	// ------------------------------------------------------------------
	for (genvar g = 0; g < N; g++) begin : g_cell
		cpc_cell #(
			.W     (W),
			.SHIFT (g)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (cvalid[g]),
			.in_x      (cx[g]),
			.in_y      (cy[g]),
			.in_vx     (cvx[g]),
			.in_vy     (cvy[g]),
			.in_z      (cz[g]),
			.in_side   (cside[g]),
			.out_valid (cvalid[g+1]),
			.out_x     (cx[g+1]),
			.out_y     (cy[g+1]),
			.out_vx    (cvx[g+1]),
			.out_vy    (cvy[g+1]),
			.out_z     (cz[g+1]),
			.out_side  (cside[g+1])
		);
	end

	// ------------------------------------------------------------------
	// output scaling: gain removal and rounding per component, azimuth
	// conversion in parallel; all five stages deep
	// ------------------------------------------------------------------
	logic                 comp;
	logic signed [DW-1:0] x_res, y_res, vx_res, vy_res, ang_res;
	logic                 x_sat, y_sat, vx_sat, vy_sat;

	// no gain to remove when the vector already lay on the x axis
	assign comp = !cside[N].skip;

	cpc_norm #(.DW(DW), .W(W)) u_norm_x (
		.clk (clk), .en (en), .in_v (cx[N]), .comp (comp),
		.out_res (x_res), .out_sat (x_sat)
	);

	cpc_norm #(.DW(DW), .W(W)) u_norm_y (
		.clk (clk), .en (en), .in_v (cy[N]), .comp (comp),
		.out_res (y_res), .out_sat (y_sat)
	);

	cpc_norm #(.DW(DW), .W(W)) u_norm_vx (
		.clk (clk), .en (en), .in_v (cvx[N]), .comp (comp),
		.out_res (vx_res), .out_sat (vx_sat)
	);

	cpc_norm #(.DW(DW), .W(W)) u_norm_vy (
		.clk (clk), .en (en), .in_v (cvy[N]), .comp (comp),
		.out_res (vy_res), .out_sat (vy_sat)
	);

	cpc_angle #(.DW(DW)) u_angle (
		.clk       (clk),
		.en        (en),
		.in_z      (cz[N]),
		.half_turn (cside[N].half_turn),
		.out_angle (ang_res)
	);

	// side band delay matching the scaling stages
	logic      tail_valid_q [CPC_END_LAT];
	cpc_side_t tail_side_q  [CPC_END_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CPC_END_LAT; i++)
				tail_valid_q[i] <= 1'b0;
		end else if (en) begin
			tail_valid_q[0] <= cvalid[N];
			for (int i = 1; i < CPC_END_LAT; i++)
				tail_valid_q[i] <= tail_valid_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tail_side_q[0] <= cside[N];
			for (int i = 1; i < CPC_END_LAT; i++)
				tail_side_q[i] <= tail_side_q[i-1];
		end
	end

	// ------------------------------------------------------------------
	// result packing: mode 0 gives radius and azimuth, mode 1 gives x and y
	// ------------------------------------------------------------------
	cpc_side_t        out_side;
	logic [FW-1:0]    r1, r2, r3, r4, r5, r6;
	logic             sat;

	assign out_side = tail_side_q[CPC_END_LAT-1];

	always_comb begin
		r1  = FW'(x_res);
		r2  = out_side.mode ? FW'(y_res) : FW'(ang_res);
		r3  = out_side.height;
		r4  = FW'(vx_res);
		r5  = FW'(vy_res);
		r6  = out_side.vz;
		// y only clips in mode 1; zero velocities never clip
		sat = x_sat || (out_side.mode && y_sat) || vx_sat || vy_sat;
	end

	assign m_tvalid   = tail_valid_q[CPC_END_LAT-1];
	assign m_tdata    = {r6, r5, r4, r3, r2, r1};
	assign m_tuser[0] = sat;

	// ------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------
	`CPC_ASSERT_NEXT(a_skid_drains, clk, arst_n, sk_valid_q && en, !sk_valid_q, "skid request not drained while the pipe moved")
	`CPC_ASSERT_NOW(a_skid_fills_on_stall, clk, arst_n, $rose(sk_valid_q), !$past(en), "skid filled without a stall")
	`CPC_ASSERT_NOW(a_no_velocity_zero, clk, arst_n, m_tvalid && !out_side.with_velocity, (r4 == '0) && (r5 == '0) && (r6 == '0), "velocity output not zero for a three-component point")

endmodule

@@ src/cpc_prep.sv @@
// ----------------------------------------------------------------------------
// cpc_prep: operand setup ahead of the cordic chain
// angle to turns conversion, guard scaling and half-plane pre-rotation
// ----------------------------------------------------------------------------
module cpc_prep #(
	parameter int DW = cpc_pkg::CPC_DATA_WIDTH,
	parameter int W  = cpc_pkg::cpc_ww(cpc_pkg::CPC_DATA_WIDTH)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic                             in_valid,
	input  cpc_pkg::cpc_item_t               in_item,
	output logic                             out_valid,
	output logic signed [W-1:0]              out_x,
	output logic signed [W-1:0]              out_y,
	output logic signed [W-1:0]              out_vx,
	output logic signed [W-1:0]              out_vy,
	output logic signed [cpc_pkg::CPC_ZW-1:0] out_z,
	output cpc_pkg::cpc_side_t               out_side
);
	import cpc_pkg::*;

	localparam int PW = DW + 35;
	localparam int XW = W - CPC_GUARD;

	logic                     valid_s1;
	cpc_item_t                item_s1;
	logic signed [PW-1:0]     prod_s1;
	logic signed [DW-1:0]     angle_in;

	logic                     valid_s2;
	logic signed [W-1:0]      x_s2, y_s2, vx_s2, vy_s2;
	logic signed [CPC_ZW-1:0] z_s2;
	cpc_side_t                side_s2;

	logic signed [XW-1:0]     fx, fy, fvx, fvy;
	logic signed [W-1:0]      gx, gy, gvx, gvy;
	logic [PW-1:0]            rsum;
	logic signed [31:0]       turn;
	logic signed [32:0]       turn_x, turn_f;
	logic                     fold, x_neg, y_zero, flip;

	assign angle_in = in_item.second_coord[DW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (en)
			valid_s1 <= in_valid;
	end

	// radians to turns product, rounded in the next stage
	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= in_item;
			prod_s1 <= PW'(angle_in) * PW'(CPC_RAD_TO_TURN);
		end
	end

	always_comb begin
		fx  = XW'(signed'(item_s1.first_coord[DW-1:0]));
		fy  = XW'(signed'(item_s1.second_coord[DW-1:0]));
		fvx = XW'(signed'(item_s1.first_velocity[DW-1:0]));
		fvy = XW'(signed'(item_s1.second_velocity[DW-1:0]));
		gx  = {fx, {CPC_GUARD{1'b0}}};
		gy  = {fy, {CPC_GUARD{1'b0}}};
		gvx = item_s1.with_velocity ? {fvx, {CPC_GUARD{1'b0}}} : '0;
		gvy = item_s1.with_velocity ? {fvy, {CPC_GUARD{1'b0}}} : '0;

		rsum   = prod_s1 + (PW'(1) << (DW - 1));
		turn   = rsum[DW+31:DW];
		turn_x = 33'(turn);
		fold   = (turn_x > CPC_QUARTER_TURN) || (turn_x < -CPC_QUARTER_TURN);
		if (!fold)
			turn_f = turn_x;
		else if (turn_x[32])
			turn_f = turn_x + CPC_HALF_TURN_S;
		else
			turn_f = turn_x - CPC_HALF_TURN_S;

		x_neg  = fx[XW-1];
		y_zero = (item_s1.second_coord[DW-1:0] == '0);
		flip   = item_s1.mode ? fold : x_neg;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (en)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s2  <= flip ? -gx : gx;
			y_s2  <= item_s1.mode ? '0 : (flip ? -gy : gy);
			vx_s2 <= flip ? -gvx : gvx;
			vy_s2 <= flip ? -gvy : gvy;
			z_s2  <= item_s1.mode ? CPC_ZW'(turn_f) : '0;
			side_s2.mode          <= item_s1.mode;
			side_s2.with_velocity <= item_s1.with_velocity;
			side_s2.skip          <= !item_s1.mode && y_zero;
			side_s2.half_turn     <= !item_s1.mode && x_neg;
			side_s2.height        <= item_s1.height;
			side_s2.vz            <= item_s1.with_velocity ? item_s1.vertical_velocity : '0;
		end
	end

	assign out_valid = valid_s2;
	assign out_x     = x_s2;
	assign out_y     = y_s2;
	assign out_vx    = vx_s2;
	assign out_vy    = vy_s2;
	assign out_z     = z_s2;
	assign out_side  = side_s2;

endmodule

@@ src/cpc_cell.sv @@
// ----------------------------------------------------------------------------
// cpc_cell: one cordic micro-rotation
// rotates position and velocity by atan(2^-SHIFT), or passes them on when skip is set, and registers the result
// ----------------------------------------------------------------------------
module cpc_cell #(
	parameter int W     = cpc_pkg::cpc_ww(cpc_pkg::CPC_DATA_WIDTH),
	parameter int SHIFT = 0
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_valid,
	input  logic signed [W-1:0]               in_x,
	input  logic signed [W-1:0]               in_y,
	input  logic signed [W-1:0]               in_vx,
	input  logic signed [W-1:0]               in_vy,
	input  logic signed [cpc_pkg::CPC_ZW-1:0] in_z,
	input  cpc_pkg::cpc_side_t                in_side,
	output logic                              out_valid,
	output logic signed [W-1:0]               out_x,
	output logic signed [W-1:0]               out_y,
	output logic signed [W-1:0]               out_vx,
	output logic signed [W-1:0]               out_vy,
	output logic signed [cpc_pkg::CPC_ZW-1:0] out_z,
	output cpc_pkg::cpc_side_t                out_side
);
	import cpc_pkg::*;

	localparam logic signed [CPC_ZW-1:0] ATAN = CPC_ZW'(cpc_atan(SHIFT));

	logic                     valid_q;
	logic signed [W-1:0]      x_q, y_q, vx_q, vy_q;
	logic signed [CPC_ZW-1:0] z_q;
	cpc_side_t                side_q;

	logic                     cw;
	logic signed [W-1:0]      xs, ys, vxs, vys;

	// vectoring drives y to zero, rotation drives the residual angle to zero
	always_comb begin
		cw  = in_side.mode ? in_z[CPC_ZW-1] : !in_y[W-1];
		xs  = in_x >>> SHIFT;
		ys  = in_y >>> SHIFT;
		vxs = in_vx >>> SHIFT;
		vys = in_vy >>> SHIFT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (en)
			valid_q <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q <= in_side;
			if (in_side.skip) begin
				x_q  <= in_x;
				y_q  <= in_y;
				vx_q <= in_vx;
				vy_q <= in_vy;
				z_q  <= in_z;
			end else if (cw) begin
				x_q  <= in_x + ys;
				y_q  <= in_y - xs;
				vx_q <= in_vx + vys;
				vy_q <= in_vy - vxs;
				z_q  <= in_z + ATAN;
			end else begin
				x_q  <= in_x - ys;
				y_q  <= in_y + xs;
				vx_q <= in_vx - vys;
				vy_q <= in_vy + vxs;
				z_q  <= in_z - ATAN;
			end
		end
	end

	assign out_valid = valid_q;
	assign out_x     = x_q;
	assign out_y     = y_q;
	assign out_vx    = vx_q;
	assign out_vy    = vy_q;
	assign out_z     = z_q;
	assign out_side  = side_q;

endmodule

@@ src/cpc_norm.sv @@
// ----------------------------------------------------------------------------
// cpc_norm: gain removal and output scaling for one component
// magnitude times inverse gain, guard rounding and saturation, five stages
// ----------------------------------------------------------------------------
module cpc_norm #(
	parameter int DW = cpc_pkg::CPC_DATA_WIDTH,
	parameter int W  = cpc_pkg::cpc_ww(cpc_pkg::CPC_DATA_WIDTH)
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [W-1:0]  in_v,
	input  logic                 comp,
	output logic signed [DW-1:0] out_res,
	output logic                 out_sat
);
	import cpc_pkg::*;

	localparam int MW = (W > 33) ? W : 33;
	localparam int HW = MW - 32;
	localparam int RW = MW + 1 - CPC_GUARD;

	logic signed [MW-1:0] vext;
	logic [MW-1:0]        mag_s1, mag_s2;
	logic                 neg_s1, neg_s2, neg_s3, neg_s4;
	logic                 comp_s1, comp_s2;
	logic [63:0]          plo_s2;
	logic [MW-1:0]        phi_s2;
	logic [MW-1:0]        m_s3;
	logic [MW:0]          rsum;
	logic [RW-1:0]        r_s4;
	logic [RW-1:0]        lim, mclip;
	logic                 over;
	logic [DW-1:0]        mlow;
	logic signed [DW-1:0] res_s5;
	logic                 sat_s5;

	assign vext = MW'(in_v);

	always_comb begin
		rsum  = {1'b0, m_s3} + ((MW + 1)'(1) << (CPC_GUARD - 1));
		lim   = RW'(1) << (DW - 1);
		over  = neg_s4 ? (r_s4 > lim) : (r_s4 > lim - 1'b1);
		if (!over)
			mclip = r_s4;
		else if (neg_s4)
			mclip = lim;
		else
			mclip = lim - 1'b1;
		mlow  = mclip[DW-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// sign and magnitude
			neg_s1  <= in_v[W-1];
			comp_s1 <= comp;
			mag_s1  <= in_v[W-1] ? (~vext + 1'b1) : vext;
			// partial products of the inverse gain
			plo_s2  <= mag_s1[31:0] * CPC_KINV;
			phi_s2  <= mag_s1[MW-1:32] * CPC_KINV;
			mag_s2  <= mag_s1;
			neg_s2  <= neg_s1;
			comp_s2 <= comp_s1;
			// product rounded at bit 32, half up
			m_s3    <= comp_s2 ? (phi_s2 + MW'(plo_s2[63:32]) + MW'(plo_s2[31])) : mag_s2;
			neg_s3  <= neg_s2;
			// drop guard bits
			r_s4    <= rsum[MW:CPC_GUARD];
			neg_s4  <= neg_s3;
			// clip and restore sign
			res_s5  <= neg_s4 ? -mlow : mlow;
			sat_s5  <= over;
		end
	end

	assign out_res = res_s5;
	assign out_sat = sat_s5;

	// keeps the width of the high partial product tied to the magnitude width
	logic [HW-1:0] hi_part;
	assign hi_part = mag_s1[MW-1:32];

endmodule

@@ src/cpc_angle.sv @@
// ----------------------------------------------------------------------------
// cpc_angle: azimuth output conversion
// turn count to signed radians in (-pi, pi], five stages
// ----------------------------------------------------------------------------
module cpc_angle #(
	parameter int DW = cpc_pkg::CPC_DATA_WIDTH
) (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [cpc_pkg::CPC_ZW-1:0] in_z,
	input  logic                              half_turn,
	output logic signed [DW-1:0]              out_angle
);
	import cpc_pkg::*;

	logic [31:0]          t_s1;
	logic [31:0]          mag_s2;
	logic                 neg_s2, neg_s3, neg_s4;
	logic [62:0]          prod_s3;
	logic [63:0]          asum;
	logic [DW-1:0]        r_s4;
	logic signed [DW-1:0] ang_s5;

	// rounding at the bit below the radian lsb
	assign asum = {1'b0, prod_s3} + (64'(1) << (63 - DW));

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1    <= in_z[31:0] + (half_turn ? CPC_HALF_TURN : 32'd0);
			// minus half turn reads as plus half turn
			neg_s2  <= t_s1[31] && (t_s1 != CPC_HALF_TURN);
			mag_s2  <= (t_s1[31] && (t_s1 != CPC_HALF_TURN)) ? (~t_s1 + 32'd1) : t_s1;
			prod_s3 <= mag_s2 * CPC_TURN_TO_RAD;
			neg_s3  <= neg_s2;
			r_s4    <= asum[63:64-DW];
			neg_s4  <= neg_s3;
			ang_s5  <= neg_s4 ? -r_s4 : r_s4;
		end
	end

	assign out_angle = ang_s5;

endmodule

@@ tb/tb_cartesian_polar_converter_core.sv @@
// ----------------------------------------------------------------------------
// tb_cartesian_polar_converter_core: self-checking bench of the point converter
// a directed set of corner points is sent first, then random streams of cartesian
// and cylindrical points; every result is predicted in the bench and compared field
// by field; all but the last test add random gaps and stalls on both buses
// ----------------------------------------------------------------------------
module tb_cartesian_polar_converter_core;

	localparam int DATA_W   = 32;
	localparam int NSTAGES  = 24;
	localparam int GUARD    = 8;
	localparam int BUS_BITS = cpc_pkg::CPC_DATA_BITS;

	// a cycle with no request accepted on either bus counts toward the watchdog
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 2 * (NSTAGES + 8);

	localparam longint          GUARD_SCALE = 256;
	localparam longint unsigned GAIN_INV    = 64'd2608131496;
	localparam longint unsigned TURN_TO_RAD = 64'd1686629713;
	localparam longint unsigned RAD_TO_TURN = 64'd10937044409;
	localparam longint          HALF_TURN   = 64'sd2147483648;
	localparam longint          QUARTER     = 64'sd1073741824;

	localparam logic signed [31:0] WORD_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] ONE_Q16  = 32'sd65536;
	// pi and pi/2 in q4.28 radians
	localparam logic signed [31:0] PI_Q28   = 32'sd843314857;
	localparam logic signed [31:0] HALF_PI  = 32'sd421657428;

	localparam bit TO_CYL  = 1'b0;
	localparam bit TO_CART = 1'b1;

	// atan(2^-i) in turns, 2^32 per turn
	localparam longint ATAN_TURNS [0:NSTAGES-1] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
		83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81
	};

	typedef struct packed {
		logic signed [31:0] first_result;
		logic signed [31:0] second_result;
		logic signed [31:0] height_out;
		logic signed [31:0] first_velocity_out;
		logic signed [31:0] second_velocity_out;
		logic signed [31:0] vertical_velocity_out;
		logic               saturated;
	} converted_point_t;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	// first_coord, second_coord, height, first_velocity, second_velocity,
	// vertical_velocity (32 bits each, lowest first)
	logic [BUS_BITS-1:0] s_tdata  = '0;
	// mode, with_velocity (lowest first)
	logic [1:0]          s_tuser  = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	// first_result, second_result, height_out, first_velocity_out,
	// second_velocity_out, vertical_velocity_out (32 bits each, lowest first)
	logic [BUS_BITS-1:0] m_tdata;
	// saturated
	logic [0:0]          m_tuser;

	converted_point_t expected_points [$];

	int idle_pct       = 0;
	int stall_left     = 0;
	int quiet_cycles   = 0;
	int points_sent    = 0;
	int cyl_requests   = 0;
	int velocity_count = 0;
	int results_seen   = 0;
	int clipped_seen   = 0;
	int mismatch_count = 0;

	cartesian_polar_converter_core #(
		.DATA_WIDTH   (DATA_W),
		.CORDIC_STAGES(NSTAGES)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------------

	// a * GAIN_INV / 2^32, rounded half up
	function automatic longint unsigned remove_gain(input longint unsigned a);
		longint unsigned hi, lo, p, carry;
		hi    = a >> 32;
		lo    = a & 64'hFFFF_FFFF;
		p     = lo * GAIN_INV;
		carry = ((p & 64'hFFFF_FFFF) + 64'h8000_0000) >> 32;
		return hi * GAIN_INV + (p >> 32) + carry;
	endfunction

	// gain removal, guard bits dropped with rounding half away from zero, clip to range
	function automatic longint drop_guard(input longint v, input bit gain,
	                                      output bit clipped);
		longint unsigned m, lim;
		clipped = 1'b0;
		lim     = 64'd1 << (DATA_W - 1);
		m       = (v < 0) ? -v : v;
		if (gain)
			m = remove_gain(m);
		m = (m + (64'd1 << (GUARD - 1))) >> GUARD;
		if (v < 0) begin
			if (m > lim) begin
				m       = lim;
				clipped = 1'b1;
			end
			return -longint'(m);
		end
		if (m > lim - 1) begin
			m       = lim - 1;
			clipped = 1'b1;
		end
		return longint'(m);
	endfunction

	function automatic converted_point_t convert_point(input cpc_pkg::cpc_item_t pt);
		converted_point_t res;
		longint           x, y, vx, vy, turns, xs, ys, vxs, vys, s;
		longint           radius_or_x, azimuth_or_y, vel_a, vel_b;
		longint unsigned  mag, p;
		logic [31:0]      t, base;
		bit               gain, clipped, any_clip;

		any_clip = 1'b0;
		gain     = 1'b1;
		turns    = 0;
		vel_a    = 0;
		vel_b    = 0;
		x        = longint'($signed(pt.first_coord)) * GUARD_SCALE;
		y        = 0;
		vx       = pt.with_velocity ? longint'($signed(pt.first_velocity)) * GUARD_SCALE : 0;
		vy       = pt.with_velocity ? longint'($signed(pt.second_velocity)) * GUARD_SCALE : 0;

		if (pt.mode == TO_CYL) begin
			y    = longint'($signed(pt.second_coord)) * GUARD_SCALE;
			base = '0;
			// left half plane: flip everything and start the angle at a half turn
			if (x < 0) begin
				x    = -x;
				y    = -y;
				vx   = -vx;
				vy   = -vy;
				base = 32'h8000_0000;
			end
			// on the x axis the vector is already aligned, no rotation and no gain
			gain = (y != 0);
			for (int i = 0; gain && i < NSTAGES; i++) begin
				xs  = x >>> i;
				ys  = y >>> i;
				vxs = vx >>> i;
				vys = vy >>> i;
				if (y >= 0) begin
					x     += ys;
					y     -= xs;
					vx    += vys;
					vy    -= vxs;
					turns += ATAN_TURNS[i];
				end else begin
					x     -= ys;
					y     += xs;
					vx    -= vys;
					vy    += vxs;
					turns -= ATAN_TURNS[i];
				end
			end
			t = base + turns[31:0];
			s = longint'($signed(t));
			// minus one half turn reads as plus one half turn
			if (s == -HALF_TURN)
				s = HALF_TURN;
			mag          = (s < 0) ? -s : s;
			mag          = (mag * TURN_TO_RAD + (64'd1 << 31)) >> 32;
			radius_or_x  = drop_guard(x, gain, clipped);
			any_clip    |= clipped;
			azimuth_or_y = (s < 0) ? -longint'(mag) : longint'(mag);
		end else begin
			// radians to turns, any angle wraps modulo one turn
			p = longint'($signed(pt.second_coord));
			p = p * RAD_TO_TURN;
			t = 32'((p + 64'h8000_0000) >> 32);
			s = longint'($signed(t));
			if (s > QUARTER || s < -QUARTER) begin
				x   = -x;
				vx  = -vx;
				vy  = -vy;
				s  += (s > 0) ? -HALF_TURN : HALF_TURN;
			end
			turns = s;
			for (int i = 0; i < NSTAGES; i++) begin
				xs  = x >>> i;
				ys  = y >>> i;
				vxs = vx >>> i;
				vys = vy >>> i;
				if (turns >= 0) begin
					x     -= ys;
					y     += xs;
					vx    -= vys;
					vy    += vxs;
					turns -= ATAN_TURNS[i];
				end else begin
					x     += ys;
					y     -= xs;
					vx    += vys;
					vy    -= vxs;
					turns += ATAN_TURNS[i];
				end
			end
			radius_or_x   = drop_guard(x, 1'b1, clipped);
			any_clip     |= clipped;
			azimuth_or_y  = drop_guard(y, 1'b1, clipped);
			any_clip     |= clipped;
		end

		res = '0;
		if (pt.with_velocity) begin
			vel_a     = drop_guard(vx, gain, clipped);
			any_clip |= clipped;
			vel_b     = drop_guard(vy, gain, clipped);
			any_clip |= clipped;
			res.vertical_velocity_out = pt.vertical_velocity;
		end
		res.first_result        = radius_or_x[31:0];
		res.second_result       = azimuth_or_y[31:0];
		res.height_out          = pt.height;
		res.first_velocity_out  = vel_a[31:0];
		res.second_velocity_out = vel_b[31:0];
		res.saturated           = any_clip;
		return res;
	endfunction

	// ------------------------------------------------------------------------
	// request side
	// ------------------------------------------------------------------------

	function automatic cpc_pkg::cpc_item_t make_point(input bit mode,
		input logic signed [31:0] c1, input logic signed [31:0] c2,
		input logic signed [31:0] h, input logic signed [31:0] v1,
		input logic signed [31:0] v2, input logic signed [31:0] v3, input bit with_vel);
		cpc_pkg::cpc_item_t pt;
		pt.mode              = mode;
		pt.first_coord       = c1;
		pt.second_coord      = c2;
		pt.height            = h;
		pt.first_velocity    = v1;
		pt.second_velocity   = v2;
		pt.vertical_velocity = v3;
		pt.with_velocity     = with_vel;
		return pt;
	endfunction

	// full-range words, extremes, and values of every magnitude with either sign
	function automatic logic signed [31:0] random_word();
		logic signed [31:0] w;
		case ($urandom_range(0, 7))
			0: begin
				case ($urandom_range(0, 4))
					0: w = WORD_MAX;
					1: w = WORD_MIN;
					2: w = 32'sd1;
					3: w = -32'sd1;
					default: w = '0;
				endcase
			end
			1: w = $urandom;
			default: begin
				w = $urandom;
				w = w >>> $urandom_range(0, 30);
			end
		endcase
		return w;
	endfunction

	// mostly within [-pi, pi], the rest anywhere in the q4.28 range
	function automatic logic signed [31:0] random_angle();
		logic signed [31:0] w;
		if ($urandom_range(0, 3) != 0)
			w = $signed(32'($urandom_range(0, 2 * PI_Q28))) - PI_Q28;
		else
			w = random_word();
		return w;
	endfunction

	function automatic cpc_pkg::cpc_item_t random_point(input bit mode);
		return make_point(mode, random_word(),
			(mode == TO_CART) ? random_angle() : random_word(),
			random_word(), random_word(), random_word(), random_word(),
			$urandom_range(0, 3) != 0);
	endfunction

	// one request: optional gap, then hold tvalid until the converter takes it
	task automatic send_point(input cpc_pkg::cpc_item_t pt);
		int gap;
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			gap = $urandom_range(1, 16);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {pt.vertical_velocity, pt.second_velocity, pt.first_velocity,
		             pt.height, pt.second_coord, pt.first_coord};
		s_tuser  <= {pt.with_velocity, pt.mode};
		do
			@(posedge clk);
		while (!s_tready);
		expected_points.push_back(convert_point(pt));
		points_sent++;
		if (pt.mode == TO_CART)
			cyl_requests++;
		if (pt.with_velocity)
			velocity_count++;
	endtask

	// ------------------------------------------------------------------------
	// result side
	// ------------------------------------------------------------------------

	// random stall bursts, none started while idle_pct is zero
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct / 4) begin
			stall_left = $urandom_range(1, 16) - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic check_field(input string label, input logic [31:0] want,
	                           input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, label, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin
		converted_point_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (m_tuser[0] === 1'b1)
				clipped_seen++;
			if (expected_points.size() == 0) begin
				$display("%0t: result with nothing expected, expected none, got %h %h",
				         $time, m_tdata, m_tuser);
				mismatch_count++;
			end else begin
				want = expected_points.pop_front();
				check_field("first_result", want.first_result, m_tdata[31:0]);
				check_field("second_result", want.second_result, m_tdata[63:32]);
				check_field("height_out", want.height_out, m_tdata[95:64]);
				check_field("first_velocity_out", want.first_velocity_out, m_tdata[127:96]);
				check_field("second_velocity_out", want.second_velocity_out,
				            m_tdata[159:128]);
				check_field("vertical_velocity_out", want.vertical_velocity_out,
				            m_tdata[191:160]);
				check_field("saturated", 32'(want.saturated), 32'(m_tuser[0]));
			end
		end
	end

	// watchdog: too long without any request or result moving
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no traffic for %0d cycles", $time, quiet_cycles);
			$display("tb: failure");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// axes, origin, both half planes, extremes, wrapping angles, no velocity
	task automatic test_corner_points();
		idle_pct = 25;
		// origin: radius and azimuth zero, velocity passed through
		send_point(make_point(TO_CYL, 0, 0, 0, ONE_Q16, -ONE_Q16, 7, 1'b1));
		// on the positive and negative x axis
		send_point(make_point(TO_CYL, 3 * ONE_Q16, 0, 5, ONE_Q16, 2 * ONE_Q16, -3, 1'b1));
		send_point(make_point(TO_CYL, -3 * ONE_Q16, 0, -5, ONE_Q16, 2 * ONE_Q16, 3, 1'b1));
		// most negative x alone: radius and negated velocity both clip
		send_point(make_point(TO_CYL, WORD_MIN, 0, WORD_MIN, WORD_MIN, WORD_MIN,
		                      WORD_MAX, 1'b1));
		send_point(make_point(TO_CYL, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MIN,
		                      WORD_MIN, 1'b1));
		send_point(make_point(TO_CYL, WORD_MIN, WORD_MIN, -1, WORD_MIN, WORD_MIN, -1, 1'b1));
		// on the y axis, both signs
		send_point(make_point(TO_CYL, 0, ONE_Q16, 1, ONE_Q16, 0, 0, 1'b1));
		send_point(make_point(TO_CYL, 0, -ONE_Q16, 1, 0, ONE_Q16, 0, 1'b1));
		// just above and below the negative x axis
		send_point(make_point(TO_CYL, -ONE_Q16, 1, 0, 1, -1, 1, 1'b1));
		send_point(make_point(TO_CYL, -ONE_Q16, -1, 0, -1, 1, -1, 1'b1));
		send_point(make_point(TO_CYL, 1, -1, 0, 1, 1, 1, 1'b1));
		// velocity inputs at their extremes but ignored
		send_point(make_point(TO_CYL, ONE_Q16, ONE_Q16, 32'sh5555_5555, WORD_MAX, WORD_MIN,
		                      WORD_MAX, 1'b0));
		send_point(make_point(TO_CART, 2 * ONE_Q16, 0, 32'shAAAA_AAAA, ONE_Q16, ONE_Q16,
		                      9, 1'b1));
		send_point(make_point(TO_CART, ONE_Q16, PI_Q28, 0, ONE_Q16, -ONE_Q16, 1, 1'b1));
		send_point(make_point(TO_CART, ONE_Q16, -PI_Q28, 0, -ONE_Q16, ONE_Q16, 1, 1'b1));
		send_point(make_point(TO_CART, ONE_Q16, HALF_PI, 0, ONE_Q16, ONE_Q16, 1, 1'b1));
		send_point(make_point(TO_CART, ONE_Q16, -HALF_PI, 0, ONE_Q16, ONE_Q16, 1, 1'b1));
		// negative radius is used as given
		send_point(make_point(TO_CART, -5 * ONE_Q16, HALF_PI / 2, 0, -ONE_Q16, ONE_Q16,
		                      2, 1'b1));
		// angles far beyond pi wrap modulo a turn
		send_point(make_point(TO_CART, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MIN,
		                      WORD_MAX, 1'b1));
		send_point(make_point(TO_CART, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MAX,
		                      WORD_MIN, 1'b1));
		send_point(make_point(TO_CART, WORD_MAX, 0, 0, WORD_MAX, 0, 0, 1'b1));
		send_point(make_point(TO_CART, WORD_MAX, HALF_PI / 2, 0, 0, WORD_MAX, 0, 1'b1));
		send_point(make_point(TO_CART, 7 * ONE_Q16, PI_Q28 / 3, 32'shFFFF_FFFF, WORD_MAX,
		                      WORD_MAX, WORD_MAX, 1'b0));
	endtask

	task automatic test_cartesian_stream();
		idle_pct = 30;
		repeat (120) send_point(random_point(TO_CYL));
	endtask

	task automatic test_cylindrical_stream();
		idle_pct = 30;
		repeat (120) send_point(random_point(TO_CART));
	endtask

	// long gaps and stalls on both buses
	task automatic test_heavy_stall_mix();
		idle_pct = 60;
		repeat (120) send_point(random_point($urandom_range(0, 1)));
	endtask

	// full rate, no gaps and no stalls
	task automatic test_back_to_back_mix();
		idle_pct = 0;
		repeat (130) send_point(random_point($urandom_range(0, 1)));
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corner_points();
		test_cartesian_stream();
		test_cylindrical_stream();
		test_heavy_stall_mix();
		test_back_to_back_mix();
		s_tvalid <= 1'b0;

		while (expected_points.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("tb: %0d points converted (%0d cylindrical to cartesian, %0d with velocity)",
		         points_sent, cyl_requests, velocity_count);
		$display("tb: %0d results compared, %0d clipped, %0d mismatches",
		         results_seen, clipped_seen, mismatch_count);
		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
